>>> src/aic_pkg.sv
`timescale 1ns / 1ps
// shared types, widths and character codes for the ascii infix calculator
package aic_pkg;

   localparam int VALUE_W = 32;
   localparam int CNT_W   = $clog2(VALUE_W);
   localparam int ACC_W   = VALUE_W + 4;

   localparam logic [VALUE_W-1:0] VALUE_CAP = {1'b1, {(VALUE_W-1){1'b0}}};
   localparam logic [VALUE_W-1:0] VALUE_MAX = {1'b0, {(VALUE_W-1){1'b1}}};

   localparam logic [2:0] ST_OK       = 3'd0;
   localparam logic [2:0] ST_CLOSE    = 3'd1;
   localparam logic [2:0] ST_WORDS    = 3'd2;
   localparam logic [2:0] ST_NUMBER   = 3'd3;
   localparam logic [2:0] ST_OPERATOR = 3'd4;
   localparam logic [2:0] ST_DIVZERO  = 3'd5;

   localparam logic [7:0] CH_NUL   = 8'h00;
   localparam logic [7:0] CH_TAB   = 8'h09;
   localparam logic [7:0] CH_SPACE = 8'h20;
   localparam logic [7:0] CH_PLUS  = 8'h2b;
   localparam logic [7:0] CH_MINUS = 8'h2d;
   localparam logic [7:0] CH_STAR  = 8'h2a;
   localparam logic [7:0] CH_SLASH = 8'h2f;
   localparam logic [7:0] CH_PCT   = 8'h25;
   localparam logic [7:0] CH_ZERO  = 8'h30;
   localparam logic [7:0] CH_NINE  = 8'h39;
   localparam logic [7:0] CH_E     = 8'h65;
   localparam logic [7:0] CH_X     = 8'h78;
   localparam logic [7:0] CH_I     = 8'h69;
   localparam logic [7:0] CH_T     = 8'h74;
   localparam logic [7:0] CH_Q     = 8'h71;
   localparam logic [7:0] CH_U     = 8'h75;

   typedef struct packed {
      logic [7:0] data_byte;
      logic       last_byte;
   } aic_req_type;

   typedef struct packed {
      logic [2:0]                status;
      logic signed [VALUE_W-1:0] value;
   } aic_rsp_type;

   typedef struct packed {
      logic feed;
      logic finish;
      logic div_load;
   } aic_cmd_type;

   typedef struct packed {
      logic need_div;
      logic div_done;
   } aic_stat_type;

endpackage

>>> src/aic_div.sv
`timescale 1ns / 1ps
// bit-serial signed divider, truncating quotient and remainder
module aic_div
   import aic_pkg::*;
(
   input  logic               clock,
   input  logic               reset,
   input  logic               start,
   input  logic [VALUE_W-1:0] dividend,
   input  logic [VALUE_W-1:0] divisor,
   output logic               done,
   output logic [VALUE_W-1:0] quotient,
   output logic [VALUE_W-1:0] remainder
);

   logic               busy_ff, busy_in;
   logic               done_ff, done_in;
   logic [CNT_W-1:0]   cnt_ff, cnt_in;
   logic [VALUE_W-1:0] rem_ff, rem_in;
   logic [VALUE_W-1:0] quo_ff, quo_in;
   logic [VALUE_W-1:0] dvs_ff, dvs_in;
   logic               neg_q_ff, neg_q_in;
   logic               neg_r_ff, neg_r_in;
   logic [VALUE_W:0]   shifted;
   logic [VALUE_W:0]   diff;

   always_comb begin
      busy_in  = busy_ff;
      done_in  = 1'b0;
      cnt_in   = cnt_ff;
      rem_in   = rem_ff;
      quo_in   = quo_ff;
      dvs_in   = dvs_ff;
      neg_q_in = neg_q_ff;
      neg_r_in = neg_r_ff;
      shifted  = {rem_ff, quo_ff[VALUE_W-1]};
      diff     = shifted - {1'b0, dvs_ff};
      if (start) begin
         busy_in  = 1'b1;
         cnt_in   = '0;
         rem_in   = '0;
         quo_in   = dividend[VALUE_W-1] ? -dividend : dividend;
         dvs_in   = divisor[VALUE_W-1] ? -divisor : divisor;
         neg_q_in = dividend[VALUE_W-1] ^ divisor[VALUE_W-1];
         neg_r_in = dividend[VALUE_W-1];
      end else if (busy_ff) begin
         if (!diff[VALUE_W]) begin
            rem_in = diff[VALUE_W-1:0];
            quo_in = {quo_ff[VALUE_W-2:0], 1'b1};
         end else begin
            rem_in = shifted[VALUE_W-1:0];
            quo_in = {quo_ff[VALUE_W-2:0], 1'b0};
         end
         cnt_in = cnt_ff + 1'b1;
         if (cnt_ff == CNT_W'(VALUE_W - 1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
      cnt_ff   <= cnt_in;
      rem_ff   <= rem_in;
      quo_ff   <= quo_in;
      dvs_ff   <= dvs_in;
      neg_q_ff <= neg_q_in;
      neg_r_ff <= neg_r_in;
   end

   assign done      = done_ff;
   assign quotient  = neg_q_ff ? -quo_ff : quo_ff;
   assign remainder = neg_r_ff ? -rem_ff : rem_ff;

   a_no_restart: assert property (@(posedge clock) disable iff (reset)
      start |-> !busy_ff) else $error("divider started while busy");
   a_done_after_busy: assert property (@(posedge clock) disable iff (reset)
      done_ff |-> $past(busy_ff)) else $error("divider done without work");
   a_rem_below_divisor: assert property (@(posedge clock) disable iff (reset)
      done_ff |-> rem_ff < dvs_ff) else $error("divider remainder too large");

endmodule

>>> src/aic_datapath.sv
`timescale 1ns / 1ps
// text parser, operand registers, arithmetic and response payload register
module aic_datapath
   import aic_pkg::*;
(
   input  logic         clock,
   input  logic         reset,
   input  aic_cmd_type  cmd,
   input  aic_req_type  req,
   output aic_stat_type stat,
   output aic_rsp_type  rsp
);

   localparam logic [3:0] KW_START = 4'd0;
   localparam logic [3:0] KW_E     = 4'd1;
   localparam logic [3:0] KW_EX    = 4'd2;
   localparam logic [3:0] KW_EXI   = 4'd3;
   localparam logic [3:0] KW_EXIT  = 4'd4;
   localparam logic [3:0] KW_Q     = 4'd5;
   localparam logic [3:0] KW_QU    = 4'd6;
   localparam logic [3:0] KW_QUI   = 4'd7;
   localparam logic [3:0] KW_QUIT  = 4'd8;
   localparam logic [3:0] KW_NONE  = 4'd15;

   function automatic logic [3:0] kw_next(input logic [3:0] st, input logic [7:0] c);
      logic [3:0] nx;
      nx = KW_NONE;
      unique case (st)
         KW_START: begin
            if (c == CH_E) nx = KW_E;
            else if (c == CH_Q) nx = KW_Q;
         end
         KW_E:    if (c == CH_X) nx = KW_EX;
         KW_EX:   if (c == CH_I) nx = KW_EXI;
         KW_EXI:  if (c == CH_T) nx = KW_EXIT;
         KW_Q:    if (c == CH_U) nx = KW_QU;
         KW_QU:   if (c == CH_I) nx = KW_QUI;
         KW_QUI:  if (c == CH_T) nx = KW_QUIT;
         default: nx = KW_NONE;
      endcase
      return nx;
   endfunction

   function automatic logic [VALUE_W-1:0] num_bits(input logic [VALUE_W-1:0] acc,
                                                  input logic ovf, input logic neg);
      logic [VALUE_W-1:0] mag;
      mag = ovf ? VALUE_CAP : acc;
      if (neg) return -mag;
      return (mag > VALUE_MAX) ? VALUE_MAX : mag;
   endfunction

   logic [2:0]         wc_ff, wc_in;
   logic               inside_ff, inside_in;
   logic               ended_ff, ended_in;
   logic [VALUE_W-1:0] acc_ff, acc_in;
   logic               ovf_ff, ovf_in;
   logic               neg_ff, neg_in;
   logic               wf_ff, wf_in;
   logic               broken_ff, broken_in;
   logic [VALUE_W-1:0] opa_ff, opa_in;
   logic               opa_good_ff, opa_good_in;
   logic [7:0]         op_ff, op_in;
   logic [3:0]         kw_ff, kw_in;
   logic               mod_ff, mod_in;
   aic_rsp_type        rsp_ff, rsp_in;

   logic [7:0]         c;
   logic               is_sep;
   logic               first;
   logic [ACC_W-1:0]   acc_ext;
   logic [ACC_W-1:0]   acc_next;
   logic [VALUE_W-1:0] opb;
   logic               num_ok;
   logic [2:0]         fin_status;
   logic [VALUE_W-1:0] fin_value;
   logic [2*VALUE_W-1:0] product;
   logic               need_div;
   logic               div_start;
   logic               div_done;
   logic [VALUE_W-1:0] div_quo;
   logic [VALUE_W-1:0] div_rem;

   assign c        = req.data_byte;
   assign is_sep   = (c == CH_SPACE) || (c == CH_TAB);
   assign first    = !inside_ff;
   assign opb      = num_bits(acc_ff, ovf_ff, neg_ff);
   assign num_ok   = wf_ff && !broken_ff;
   assign product  = opa_ff * opb;

   always_comb begin
      fin_status = ST_OK;
      fin_value  = '0;
      need_div   = 1'b0;
      if (kw_ff == KW_EXIT || kw_ff == KW_QUIT) begin
         fin_status = ST_CLOSE;
      end else if (wc_ff != 3'd3) begin
         fin_status = ST_WORDS;
      end else if (!opa_good_ff || !num_ok) begin
         fin_status = ST_NUMBER;
      end else begin
         case (op_ff)
            CH_PLUS:  fin_value = opa_ff + opb;
            CH_MINUS: fin_value = opa_ff - opb;
            CH_STAR:  fin_value = product[VALUE_W-1:0];
            CH_SLASH, CH_PCT: begin
               if (opb == '0) fin_status = ST_DIVZERO;
               else need_div = 1'b1;
            end
            default:  fin_status = ST_OPERATOR;
         endcase
      end
   end

   always_comb begin
      wc_in       = wc_ff;
      inside_in   = inside_ff;
      ended_in    = ended_ff;
      acc_in      = acc_ff;
      ovf_in      = ovf_ff;
      neg_in      = neg_ff;
      wf_in       = wf_ff;
      broken_in   = broken_ff;
      opa_in      = opa_ff;
      opa_good_in = opa_good_ff;
      op_in       = op_ff;
      kw_in       = kw_ff;
      mod_in      = mod_ff;
      rsp_in      = rsp_ff;
      acc_ext     = '0;
      acc_next    = '0;
      if (cmd.feed && !ended_ff) begin
         if (c == CH_NUL) begin
            ended_in = 1'b1;
         end else begin
            kw_in = kw_next(kw_ff, c);
            if (is_sep) begin
               if (inside_ff) begin
                  if (wc_ff == 3'd1) begin
                     opa_in      = opb;
                     opa_good_in = num_ok;
                  end
                  inside_in = 1'b0;
               end
            end else begin
               if (first) begin
                  inside_in = 1'b1;
                  if (wc_ff < 3'd4) wc_in = wc_ff + 3'd1;
                  if (wc_ff == 3'd1) op_in = c;
                  acc_in    = '0;
                  ovf_in    = 1'b0;
                  neg_in    = 1'b0;
                  wf_in     = 1'b0;
                  broken_in = 1'b0;
               end
               if (first && (c == CH_PLUS || c == CH_MINUS)) begin
                  neg_in = (c == CH_MINUS);
               end else if (c >= CH_ZERO && c <= CH_NINE) begin
                  wf_in = 1'b1;
                  if (!ovf_in) begin
                     acc_ext  = {4'b0, acc_in};
                     acc_next = (acc_ext << 3) + (acc_ext << 1)
                              + ACC_W'(c - CH_ZERO);
                     if (acc_next > {4'b0, VALUE_CAP}) begin
                        ovf_in = 1'b1;
                        acc_in = VALUE_CAP;
                     end else begin
                        acc_in = acc_next[VALUE_W-1:0];
                     end
                  end
               end else begin
                  broken_in = 1'b1;
               end
            end
         end
      end
      if (cmd.finish) begin
         if (need_div) begin
            mod_in = (op_ff == CH_PCT);
         end else begin
            rsp_in.status = fin_status;
            rsp_in.value  = (fin_status == ST_OK) ? fin_value : '0;
         end
         wc_in       = '0;
         inside_in   = 1'b0;
         ended_in    = 1'b0;
         acc_in      = '0;
         ovf_in      = 1'b0;
         neg_in      = 1'b0;
         wf_in       = 1'b0;
         broken_in   = 1'b0;
         opa_in      = '0;
         opa_good_in = 1'b0;
         op_in       = '0;
         kw_in       = KW_START;
      end
      if (cmd.div_load) begin
         rsp_in.status = ST_OK;
         rsp_in.value  = mod_ff ? div_rem : div_quo;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wc_ff       <= '0;
         inside_ff   <= 1'b0;
         ended_ff    <= 1'b0;
         acc_ff      <= '0;
         ovf_ff      <= 1'b0;
         neg_ff      <= 1'b0;
         wf_ff       <= 1'b0;
         broken_ff   <= 1'b0;
         opa_ff      <= '0;
         opa_good_ff <= 1'b0;
         op_ff       <= '0;
         kw_ff       <= KW_START;
      end else begin
         wc_ff       <= wc_in;
         inside_ff   <= inside_in;
         ended_ff    <= ended_in;
         acc_ff      <= acc_in;
         ovf_ff      <= ovf_in;
         neg_ff      <= neg_in;
         wf_ff       <= wf_in;
         broken_ff   <= broken_in;
         opa_ff      <= opa_in;
         opa_good_ff <= opa_good_in;
         op_ff       <= op_in;
         kw_ff       <= kw_in;
      end
      mod_ff <= mod_in;
      rsp_ff <= rsp_in;
   end

   assign div_start = cmd.finish && need_div;

   aic_div u_div (
      .clock     (clock),
      .reset     (reset),
      .start     (div_start),
      .dividend  (opa_ff),
      .divisor   (opb),
      .done      (div_done),
      .quotient  (div_quo),
      .remainder (div_rem)
   );

   assign stat.need_div = need_div;
   assign stat.div_done = div_done;
   assign rsp           = rsp_ff;

endmodule

>>> src/aic_ctrl.sv
`timescale 1ns / 1ps
// message sequencing: byte intake, evaluation, division wait, response valid
module aic_ctrl
   import aic_pkg::*;
(
   input  logic         clock,
   input  logic         reset,
   input  logic         req_valid,
   input  logic         req_last,
   output logic         req_ready,
   output logic         rsp_valid,
   input  logic         rsp_ready,
   input  aic_stat_type stat,
   output aic_cmd_type  cmd
);

   typedef enum logic [1:0] {
      S_RUN,
      S_CALC,
      S_DIV
   } state_type;

   state_type state_ff;
   logic      rsp_valid_ff;
   logic      take;

   assign req_ready    = (state_ff == S_RUN);
   assign take         = req_valid && req_ready;
   assign cmd.feed     = take;
   assign cmd.finish   = (state_ff == S_CALC) && !rsp_valid_ff;
   assign cmd.div_load = (state_ff == S_DIV) && stat.div_done;
   assign rsp_valid    = rsp_valid_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_RUN;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (rsp_valid_ff && rsp_ready) rsp_valid_ff <= 1'b0;
         unique case (state_ff)
            S_RUN: begin
               if (take && req_last) state_ff <= S_CALC;
            end
            S_CALC: begin
               if (cmd.finish) begin
                  if (stat.need_div) begin
                     state_ff <= S_DIV;
                  end else begin
                     rsp_valid_ff <= 1'b1;
                     state_ff     <= S_RUN;
                  end
               end
            end
            S_DIV: begin
               if (stat.div_done) begin
                  rsp_valid_ff <= 1'b1;
                  state_ff     <= S_RUN;
               end
            end
            default: state_ff <= S_RUN;
         endcase
      end
   end

   a_div_slot_free: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_DIV) |-> !rsp_valid_ff)
      else $error("division running while a response is pending");

endmodule

>>> src/ascii_infix_calculator.sv
`timescale 1ns / 1ps
// top level of the ascii infix calculator
// Message bytes are taken one per cycle, including while a previous response
// waits to be taken. After the flagged last byte the block evaluates the
// message; +, - and * (or any error status) give a response on the next
// cycle. / and % run through a bit-serial divider that resolves one quotient
// bit per cycle, and their response appears when the divider is done. A
// response that is still pending when the next message ends holds off that
// evaluation until it is taken; no new bytes are accepted during evaluation
// or division.
module ascii_infix_calculator
   import aic_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_ready,
   input  aic_req_type req_payload,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output aic_rsp_type rsp_payload
);

   aic_cmd_type  cmd;
   aic_stat_type stat;

   aic_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_last  (req_payload.last_byte),
      .req_ready (req_ready),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .stat      (stat),
      .cmd       (cmd)
   );

   aic_datapath u_datapath (
      .clock (clock),
      .reset (reset),
      .cmd   (cmd),
      .req   (req_payload),
      .stat  (stat),
      .rsp   (rsp_payload)
   );

endmodule

>>> test/ascii_infix_calculator_tb.sv
`timescale 1ns / 1ps
// testbench for the ascii infix calculator: directed and random messages against a local predictor
module ascii_infix_calculator_tb;
   import aic_pkg::*;

   localparam int          CYCLE_LIMIT = 400000;
   localparam logic [63:0] CAP64       = 64'(1) << (VALUE_W - 1);

   typedef enum logic [3:0] {
      KW_START = 4'd0,
      KW_E     = 4'd1,
      KW_EX    = 4'd2,
      KW_EXI   = 4'd3,
      KW_EXIT  = 4'd4,
      KW_Q     = 4'd5,
      KW_QU    = 4'd6,
      KW_QUI   = 4'd7,
      KW_QUIT  = 4'd8,
      KW_NONE  = 4'd15
   } keyword_state_type;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_valid = 1'b0;
   logic        req_ready;
   aic_req_type req_payload = '0;
   logic        rsp_valid;
   logic        rsp_ready = 1'b0;
   aic_rsp_type rsp_payload;

   ascii_infix_calculator u_top (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_ready   (req_ready),
      .req_payload (req_payload),
      .rsp_valid   (rsp_valid),
      .rsp_ready   (rsp_ready),
      .rsp_payload (rsp_payload)
   );

   always #10 clock = ~clock;

   // calculator state as predicted
   logic [2:0]        calc_words;
   bit                calc_in_word;
   bit                calc_text_done;
   logic [63:0]       calc_mag;
   bit                calc_mag_ovf;
   bit                calc_neg;
   bit                calc_has_digit;
   bit                calc_broken;
   logic [31:0]       calc_lhs;
   bit                calc_lhs_ok;
   logic [7:0]        calc_op;
   keyword_state_type calc_kw;

   aic_rsp_type pending_answers[$];
   logic [7:0]  msg_buf[$];

   int  mismatch_cnt = 0;
   int  checked_cnt = 0;
   int  bytes_sent = 0;
   int  messages_sent = 0;
   int  answers_predicted = 0;
   int  status_seen[6];
   int  cycle_cnt = 0;
   int  stall_left = 0;
   bit  src_gaps = 1'b0;
   bit  sink_stalls = 1'b0;
   bit  idle_allowed = 1'b1;

   string alpha = "abcdefghijklmnopqrstuvwxyz";
   string digits = "0123456789";
   string ops = "+-*/%";
   string bad_ops = "x^&=<.!p";

   function automatic void clear_calc();
      calc_words     = '0;
      calc_in_word   = 1'b0;
      calc_text_done = 1'b0;
      calc_mag       = '0;
      calc_mag_ovf   = 1'b0;
      calc_neg       = 1'b0;
      calc_has_digit = 1'b0;
      calc_broken    = 1'b0;
      calc_lhs       = '0;
      calc_lhs_ok    = 1'b0;
      calc_op        = '0;
      calc_kw        = KW_START;
   endfunction

   function automatic keyword_state_type keyword_step(keyword_state_type st, logic [7:0] c);
      case (st)
         KW_START: begin
            if (c == CH_E) return KW_E;
            if (c == CH_Q) return KW_Q;
            return KW_NONE;
         end
         KW_E:   return (c == CH_X) ? KW_EX : KW_NONE;
         KW_EX:  return (c == CH_I) ? KW_EXI : KW_NONE;
         KW_EXI: return (c == CH_T) ? KW_EXIT : KW_NONE;
         KW_Q:   return (c == CH_U) ? KW_QU : KW_NONE;
         KW_QU:  return (c == CH_I) ? KW_QUI : KW_NONE;
         KW_QUI: return (c == CH_T) ? KW_QUIT : KW_NONE;
         default: return KW_NONE;
      endcase
   endfunction

   // saturated two's complement value of the word being scanned
   function automatic logic [31:0] operand_bits();
      logic [63:0] m;
      m = calc_mag_ovf ? CAP64 : calc_mag;
      if (calc_neg) return 32'(64'd0 - m);
      return (m > CAP64 - 1) ? 32'(CAP64 - 1) : 32'(m);
   endfunction

   function automatic void scan_char(logic [7:0] c);
      bit          first;
      logic [63:0] d;
      first = 1'b0;
      calc_kw = keyword_step(calc_kw, c);
      if (c == CH_SPACE || c == CH_TAB) begin
         if (calc_in_word) begin
            if (calc_words == 3'd1) begin
               calc_lhs    = operand_bits();
               calc_lhs_ok = calc_has_digit && !calc_broken;
            end
            calc_in_word = 1'b0;
         end
         return;
      end
      if (!calc_in_word) begin
         calc_in_word   = 1'b1;
         first          = 1'b1;
         if (calc_words < 3'd4) calc_words = calc_words + 3'd1;
         calc_mag       = '0;
         calc_mag_ovf   = 1'b0;
         calc_neg       = 1'b0;
         calc_has_digit = 1'b0;
         calc_broken    = 1'b0;
         if (calc_words == 3'd2) calc_op = c;
      end
      if (first && (c == CH_PLUS || c == CH_MINUS)) begin
         calc_neg = (c == CH_MINUS);
      end else if (c >= CH_ZERO && c <= CH_NINE) begin
         d = 64'(c - CH_ZERO);
         calc_has_digit = 1'b1;
         if (!calc_mag_ovf) begin
            if (calc_mag > (CAP64 - d) / 10) begin
               calc_mag_ovf = 1'b1;
               calc_mag     = CAP64;
            end else begin
               calc_mag = calc_mag * 10 + d;
            end
         end
      end else begin
         calc_broken = 1'b1;
      end
   endfunction

   function automatic aic_rsp_type evaluate_expression();
      aic_rsp_type        r;
      logic [31:0]        a;
      logic [31:0]        b;
      logic signed [31:0] sa;
      logic signed [31:0] sb;
      r.status = ST_OK;
      r.value  = '0;
      if (calc_kw == KW_EXIT || calc_kw == KW_QUIT) begin
         r.status = ST_CLOSE;
      end else if (calc_words != 3'd3) begin
         r.status = ST_WORDS;
      end else if (!calc_lhs_ok || !(calc_has_digit && !calc_broken)) begin
         r.status = ST_NUMBER;
      end else begin
         a  = calc_lhs;
         b  = operand_bits();
         sa = a;
         sb = b;
         case (calc_op)
            CH_PLUS:  r.value = a + b;
            CH_MINUS: r.value = a - b;
            CH_STAR:  r.value = a * b;
            CH_SLASH, CH_PCT: begin
               if (sb == 0) begin
                  r.status = ST_DIVZERO;
               end else if (sb == -1) begin
                  r.value = (calc_op == CH_SLASH) ? 32'd0 - a : 32'd0;
               end else begin
                  r.value = (calc_op == CH_SLASH) ? sa / sb : sa % sb;
               end
            end
            default: r.status = ST_OPERATOR;
         endcase
      end
      if (r.status != ST_OK) r.value = '0;
      return r;
   endfunction

   function automatic void predict_byte(logic [7:0] c, logic last);
      aic_rsp_type r;
      if (!calc_text_done) begin
         if (c == CH_NUL) calc_text_done = 1'b1;
         else scan_char(c);
      end
      if (last) begin
         r = evaluate_expression();
         pending_answers.push_back(r);
         answers_predicted++;
         status_seen[r.status]++;
         clear_calc();
      end
   endfunction

   task automatic flag_error(string msg);
      mismatch_cnt++;
      if (mismatch_cnt <= 10) $display("mismatch: %s", msg);
   endtask

   // result side: random stall bursts when sink stalls are enabled, else always ready
   always @(posedge clock) begin
      if (!sink_stalls) begin
         stall_left <= 0;
         rsp_ready  <= 1'b1;
      end else if (stall_left != 0) begin
         stall_left <= stall_left - 1;
         rsp_ready  <= 1'b0;
      end else if ($urandom_range(0, 4) == 0) begin
         stall_left <= $urandom_range(0, 16);
         rsp_ready  <= 1'b0;
      end else begin
         rsp_ready <= 1'b1;
      end
   end

   always @(posedge clock) begin : check_rsp
      aic_rsp_type want;
      if (!reset && rsp_valid && rsp_ready) begin
         checked_cnt++;
         if (pending_answers.size() == 0) begin
            flag_error($sformatf("transaction with nothing pending: status %0d value %0d",
                                 rsp_payload.status, rsp_payload.value));
         end else begin
            want = pending_answers.pop_front();
            if (rsp_payload.status !== want.status || rsp_payload.value !== want.value)
               flag_error($sformatf({"result %0d: expected status %0d value %0d, ",
                                     "got status %0d value %0d"},
                                    checked_cnt, want.status, want.value,
                                    rsp_payload.status, rsp_payload.value));
         end
      end
   end

   always @(posedge clock) begin
      cycle_cnt++;
      if (cycle_cnt > CYCLE_LIMIT) begin
         $display("timeout after %0d cycles", cycle_cnt);
         $display("FAILED: results differ");
         $finish;
      end
   end

   task automatic send_byte(logic [7:0] c, logic last);
      int gap;
      if (src_gaps && $urandom_range(0, 5) == 0) begin
         gap = $urandom_range(1, 17);
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid   <= 1'b1;
      req_payload <= '{data_byte: c, last_byte: last};
      @(posedge clock);
      while (req_ready !== 1'b1) @(posedge clock);
      bytes_sent++;
      predict_byte(c, last);
   endtask

   task automatic send_msg();
      if (msg_buf.size() == 0) msg_buf.push_back(CH_NUL);
      if (idle_allowed) begin
         src_gaps    = ($urandom_range(0, 3) != 0);
         sink_stalls = ($urandom_range(0, 3) != 0);
      end else begin
         src_gaps    = 1'b0;
         sink_stalls = 1'b0;
      end
      foreach (msg_buf[i]) send_byte(msg_buf[i], i == msg_buf.size() - 1);
      msg_buf.delete();
      messages_sent++;
   endtask

   task automatic put_str(string s);
      for (int i = 0; i < s.len(); i++) msg_buf.push_back(s[i]);
   endtask

   task automatic send_text(string s);
      put_str(s);
      send_msg();
   endtask

   task automatic put_sep();
      int n;
      n = $urandom_range(1, 3);
      repeat (n) msg_buf.push_back($urandom_range(0, 1) ? CH_SPACE : CH_TAB);
   endtask

   task automatic put_number();
      int n;
      case ($urandom_range(0, 3))
         0: msg_buf.push_back(CH_PLUS);
         1: msg_buf.push_back(CH_MINUS);
         default: ;
      endcase
      if ($urandom_range(0, 9) == 0) put_str("00");
      case ($urandom_range(0, 9))
         0, 1, 2, 3, 4: put_str($sformatf("%0d", $urandom_range(0, 99)));
         5, 6: put_str($sformatf("%0d", $urandom));
         7: begin
            case ($urandom_range(0, 4))
               0: put_str("2147483647");
               1: put_str("2147483648");
               2: put_str("2147483649");
               3: put_str("0");
               default: put_str("1");
            endcase
         end
         default: begin
            n = $urandom_range(11, 20);
            msg_buf.push_back(digits[$urandom_range(1, 9)]);
            repeat (n - 1) msg_buf.push_back(digits[$urandom_range(0, 9)]);
         end
      endcase
   endtask

   task automatic put_op();
      int n;
      if ($urandom_range(0, 19) < 18) msg_buf.push_back(ops[$urandom_range(0, 4)]);
      else msg_buf.push_back(bad_ops[$urandom_range(0, bad_ops.len() - 1)]);
      if ($urandom_range(0, 7) == 0) begin
         n = $urandom_range(1, 2);
         repeat (n) msg_buf.push_back(alpha[$urandom_range(0, 25)]);
      end
   endtask

   task automatic put_expression();
      if ($urandom_range(0, 3) == 0) put_sep();
      put_number();
      put_sep();
      put_op();
      put_sep();
      put_number();
      if ($urandom_range(0, 3) == 0) put_sep();
   endtask

   task automatic build_random_message();
      string kw_words[8];
      int    k;
      int    n;
      kw_words = '{"exit", "quit", "exi", "qui", "exitt", "quitx", "Exit", "xexit"};
      k = $urandom_range(0, 99);
      if (k < 60) begin
         put_expression();
         if ($urandom_range(0, 9) == 0) begin
            msg_buf.push_back(CH_NUL);
            put_str("9 9");
         end
      end else if (k < 68) begin
         if ($urandom_range(0, 5) == 0) put_sep();
         put_str(kw_words[$urandom_range(0, 7)]);
         case ($urandom_range(0, 5))
            0: put_sep();
            1: begin
               msg_buf.push_back(CH_NUL);
               put_str("zz");
            end
            default: ;
         endcase
      end else if (k < 76) begin
         n = $urandom_range(0, 6);
         if (n == 3) n = 4;
         if (n == 0) put_sep();
         for (int i = 0; i < n; i++) begin
            if (i > 0) put_sep();
            if (i == 1) put_op();
            else put_number();
         end
      end else if (k < 86) begin
         put_number();
         case ($urandom_range(0, 3))
            0: begin
               msg_buf.push_back(alpha[$urandom_range(0, 25)]);
               put_sep();
               put_op();
               put_sep();
               put_number();
            end
            1: begin
               put_sep();
               put_op();
               put_sep();
               msg_buf.push_back($urandom_range(0, 1) ? CH_PLUS : CH_MINUS);
            end
            2: begin
               put_sep();
               put_op();
               put_sep();
               put_number();
               msg_buf.push_back(CH_MINUS);
               msg_buf.push_back(digits[$urandom_range(0, 9)]);
            end
            default: begin
               put_sep();
               msg_buf.push_back(CH_NUL);
               put_op();
               put_sep();
               put_number();
            end
         endcase
      end else begin
         n = $urandom_range(1, 12);
         repeat (n) msg_buf.push_back(8'($urandom_range(0, 255)));
      end
   endtask

   task automatic pause_until_drained();
      req_valid <= 1'b0;
      @(posedge clock);
      while (pending_answers.size() != 0) @(posedge clock);
      repeat (4) @(posedge clock);
   endtask

   task automatic test_arithmetic();
      send_text("12 + 30");
      send_text("-7 - +9");
      send_text("6 * -4");
      send_text("-7 / 2");
      send_text("-7 % 2");
      send_text("3\t*\t5");
      send_text(" 8   % -3 ");
      send_text("4 +abc 2");
      send_text("2147483647 * 2147483647");
   endtask

   task automatic test_saturation();
      send_text("99999999999 + 1");
      send_text("-99999999999 - 1");
      send_text("-2147483648 / -1");
      send_text("-2147483648 % -1");
   endtask

   task automatic test_keywords();
      send_text("exit");
      send_text("quit");
      send_text("ex");
      send_text("quits");
      put_str("exit");
      msg_buf.push_back(CH_NUL);
      send_text("junk");
   endtask

   task automatic test_errors();
      msg_buf.push_back(CH_NUL);
      send_msg();
      send_text("1 +");
      send_text("1 + 2 3");
      send_text("1x + 2");
      send_text("1 + -");
      send_text("4 plus 2");
      send_text("x ? y");
      send_text("1 ? 0");
      send_text("5 / 0");
   endtask

   task automatic test_text_end();
      put_str("7 * 6");
      msg_buf.push_back(CH_NUL);
      send_text("99");
      put_str("7 - 6");
      msg_buf.push_back(CH_NUL);
      send_msg();
   endtask

   task automatic test_drain_pause();
      send_text("-1000000 / 7");
      pause_until_drained();
      send_text("1000000 % 7");
      pause_until_drained();
   endtask

   task automatic test_random_messages(int n_bytes, int min_answers, bit with_idle);
      int b0;
      int a0;
      b0 = bytes_sent;
      a0 = answers_predicted;
      idle_allowed = with_idle;
      while (bytes_sent - b0 < n_bytes || answers_predicted - a0 < min_answers) begin
         build_random_message();
         send_msg();
      end
   endtask

   initial begin
      clear_calc();
      foreach (status_seen[i]) status_seen[i] = 0;
      repeat (7) @(posedge clock);
      reset <= 1'b0;

      test_arithmetic();
      test_saturation();
      test_keywords();
      test_errors();
      test_text_end();
      test_random_messages(230, 12, 1'b1);
      test_drain_pause();
      test_random_messages(70, 4, 1'b0);

      req_valid <= 1'b0;
      @(posedge clock);
      while (pending_answers.size() != 0) @(posedge clock);
      repeat (50) @(posedge clock);

      $display("sent %0d bytes in %0d messages, checked %0d results",
               bytes_sent, messages_sent, checked_cnt);
      $display({"ok %0d, close %0d, word count %0d, bad number %0d, ",
                "bad operator %0d, div by zero %0d"},
               status_seen[ST_OK], status_seen[ST_CLOSE], status_seen[ST_WORDS],
               status_seen[ST_NUMBER], status_seen[ST_OPERATOR], status_seen[ST_DIVZERO]);
      if (mismatch_cnt == 0) begin
         $display("PASSED: all results match");
      end else begin
         $display("%0d mismatches", mismatch_cnt);
         $display("FAILED: results differ");
      end
      $finish;
   end

endmodule

>>> filelist.f
src/aic_pkg.sv
src/aic_div.sv
src/aic_datapath.sv
src/aic_ctrl.sv
src/ascii_infix_calculator.sv
test/ascii_infix_calculator_tb.sv
